FILE: rtl/tfla_pkg.sv
// Shared types and codes of the tile free-list allocator.
`default_nettype none

package tfla_pkg;

  // Field widths of the external item format
  localparam int HEAP_W   = 4;
  localparam int TILE_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 11;
  localparam int HCNT_W   = 5;
  localparam int MAXH_W   = 5;

  // One free-stack entry
  typedef struct packed {
    logic [HEAP_W-1:0] heap;
    logic [TILE_W-1:0] tile;
  } entry_t;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FAIL = 2'd1;
  localparam status_t ST_DROP = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage : tfla_pkg

`default_nettype wire

FILE: rtl/tile_free_list_allocator_core.sv
// Top level of the tile free-list allocator: sequencer, counters and result register.
`default_nettype none

// Tile free-list allocator. Tiles (heap, tile) live on a LIFO free stack
// held in a synchronous RAM of MAX_HEAPS*TILES_PER_BLOCK entries.
// Input channel (in_valid/in_stall): one beat is an allocate of in_count
// tiles or a free of one tile. The block takes one beat at a time and
// stalls the input until every result beat of that item is in the output
// register. Result channel (out_valid/out_stall): one beat per allocated
// tile, last marking the final one; a free, a zero-count request or a
// failed allocate gives a single beat with tile_valid low.
// Steps: a free, a zero-count or an oversized request goes from accept to
// the response state, which loads its beat into the output register. An
// allocate first checks the stack depth; for every heap it must add it
// pushes that heap's tiles, one RAM write per pushed tile, and checks again;
// then for each tile it reads the RAM and loads the result. A failure at the
// heap limit ends with loading its beat. The single RAM port pair has
// registered read data.
// cfg_max_heaps is always ready; the user must write it only while the block idles, which the block does not enforce.
// Reset (rst_n low, synchronous) empties the stack, clears the heap and
// used counters, sets max_heaps to 16 and drops any pending result.
// A stalled output holds its beat; the sequencer waits behind it.

module tile_free_list_allocator_core #(
  parameter int MAX_HEAPS       = 16,
  parameter int TILES_PER_BLOCK = 64,
  parameter int MAX_REQUEST     = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_operation,
  input  wire [tfla_pkg::COUNT_W-1:0]      in_count,
  input  wire [tfla_pkg::HEAP_W-1:0]       in_freed_heap,
  input  wire [tfla_pkg::TILE_W-1:0]       in_freed_tile,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [tfla_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_tile_valid,
  output logic [tfla_pkg::HEAP_W-1:0]      out_heap_index,
  output logic [tfla_pkg::TILE_W-1:0]      out_tile_index,
  output logic                             out_last,
  output logic [tfla_pkg::USED_W-1:0]      out_used_count,
  output logic [tfla_pkg::HCNT_W-1:0]      out_heap_count,
  // configuration
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [tfla_pkg::MAXH_W-1:0]       cfg_max_heaps
);
  import tfla_pkg::*;

  localparam int CAP   = MAX_HEAPS * TILES_PER_BLOCK;
  localparam int AW    = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int DW    = $clog2(CAP + 1);
  localparam int CMPW  = (DW > COUNT_W) ? DW : COUNT_W;
  localparam int HW    = $clog2(MAX_HEAPS + 1);
  localparam int LW    = (HW > MAXH_W) ? HW : MAXH_W;
  localparam int GW    = (TILES_PER_BLOCK > 1) ? $clog2(TILES_PER_BLOCK) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_GROW  = 6'b000100,
    S_READ  = 6'b001000,
    S_WAIT  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [DW-1:0]         depth_r, depth_nxt;
  logic [HW-1:0]         heaps_r, heaps_nxt;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [MAXH_W-1:0]     maxh_r, maxh_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [COUNT_W-1:0]    left_r, left_nxt;
  logic [GW-1:0]         grow_r, grow_nxt;
  status_t               pend_r, pend_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [HEAP_W-1:0]     out_heap_r, out_heap_nxt;
  logic [TILE_W-1:0]     out_tile_r, out_tile_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [USED_W-1:0]     out_used_r, out_used_nxt;
  logic [HW-1:0]         out_hcnt_r, out_hcnt_nxt;

  // RAM port signals
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  entry_t                mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  entry_t                mem_rdata;

  logic                  full;
  logic                  out_free;
  logic [CMPW-1:0]       depth_ext, need_ext;
  logic [LW-1:0]         heaps_ext, maxh_ext, limit;
  logic [USED_W:0]       used_sum;

  tfla_stack_mem #(
    .DEPTH (CAP),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign full      = (depth_r == DW'(CAP));
  assign out_free  = !out_valid_r || !out_stall;
  assign depth_ext = CMPW'(depth_r);
  assign need_ext  = CMPW'(count_r);
  assign heaps_ext = LW'(heaps_r);
  assign maxh_ext  = LW'(maxh_r);
  assign limit     = (maxh_ext < LW'(MAX_HEAPS)) ? maxh_ext : LW'(MAX_HEAPS);
  assign used_sum  = (USED_W+1)'(used_r) + (USED_W+1)'(count_r);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    depth_nxt      = depth_r;
    heaps_nxt      = heaps_r;
    used_nxt       = used_r;
    maxh_nxt       = maxh_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    grow_nxt       = grow_r;
    pend_nxt       = pend_r;

    // drop the beat once the receiver takes it
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_tvalid_nxt = out_tvalid_r;
    out_heap_nxt   = out_heap_r;
    out_tile_nxt   = out_tile_r;
    out_last_nxt   = out_last_r;
    out_used_nxt   = out_used_r;
    out_hcnt_nxt   = out_hcnt_r;

    mem_we         = 1'b0;
    mem_waddr      = AW'(depth_r);
    mem_wdata      = '{heap: in_freed_heap, tile: in_freed_tile};
    mem_re         = 1'b0;
    mem_raddr      = AW'(depth_r - DW'(1));

    if (cfg_valid) begin
      maxh_nxt = cfg_max_heaps;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_FREE) begin
            // push the freed tile, or drop it when the stack is full
            if (!full) begin
              mem_we    = 1'b1;
              depth_nxt = depth_r + DW'(1);
              pend_nxt  = ST_OK;
            end else begin
              pend_nxt  = ST_DROP;
            end
            if (used_r != '0) begin
              used_nxt = used_r - USED_W'(1);
            end
            state_nxt = S_RESP;
          end else if (in_count == '0) begin
            pend_nxt  = ST_OK;
            state_nxt = S_RESP;
          end else if (in_count > COUNT_W'(MAX_REQUEST)) begin
            pend_nxt  = ST_FAIL;
            state_nxt = S_RESP;
          end else begin
            count_nxt = in_count;
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (depth_ext >= need_ext) begin
          // enough tiles on the stack: commit the run
          used_nxt  = used_sum[USED_W] ? {USED_W{1'b1}} : used_sum[USED_W-1:0];
          left_nxt  = count_r;
          state_nxt = S_READ;
        end else if (heaps_ext >= limit) begin
          pend_nxt  = ST_FAIL;
          state_nxt = S_RESP;
        end else begin
          grow_nxt  = GW'(TILES_PER_BLOCK - 1);
          state_nxt = S_GROW;
        end
      end

      S_GROW: begin
        // push the new heap top tile first so tile zero pops first
        if (!full) begin
          mem_we    = 1'b1;
          mem_wdata = '{heap: HEAP_W'(heaps_r), tile: TILE_W'(grow_r)};
          depth_nxt = depth_r + DW'(1);
        end
        if (grow_r == '0) begin
          heaps_nxt = heaps_r + HW'(1);
          state_nxt = S_CHECK;
        end else begin
          grow_nxt  = grow_r - GW'(1);
        end
      end

      S_READ: begin
        mem_re    = 1'b1;
        depth_nxt = depth_r - DW'(1);
        state_nxt = S_WAIT;
      end

      S_WAIT: begin
        // RAM word is held until the output slot frees up
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_tvalid_nxt = 1'b1;
          out_heap_nxt   = mem_rdata.heap;
          out_tile_nxt   = mem_rdata.tile;
          out_last_nxt   = (left_r == COUNT_W'(1));
          out_used_nxt   = used_r;
          out_hcnt_nxt   = heaps_r;
          left_nxt       = left_r - COUNT_W'(1);
          state_nxt      = (left_r == COUNT_W'(1)) ? S_IDLE : S_READ;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_r;
          out_tvalid_nxt = 1'b0;
          out_heap_nxt   = '0;
          out_tile_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_used_nxt   = used_r;
          out_hcnt_nxt   = heaps_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      heaps_r     <= '0;
      used_r      <= '0;
      maxh_r      <= MAXH_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      heaps_r     <= heaps_nxt;
      used_r      <= used_nxt;
      maxh_r      <= maxh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    count_r      <= count_nxt;
    left_r       <= left_nxt;
    grow_r       <= grow_nxt;
    pend_r       <= pend_nxt;
    out_status_r <= out_status_nxt;
    out_tvalid_r <= out_tvalid_nxt;
    out_heap_r   <= out_heap_nxt;
    out_tile_r   <= out_tile_nxt;
    out_last_r   <= out_last_nxt;
    out_used_r   <= out_used_nxt;
    out_hcnt_r   <= out_hcnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_tile_valid = out_tvalid_r;
  assign out_heap_index = out_heap_r;
  assign out_tile_index = out_tile_r;
  assign out_last       = out_last_r;
  assign out_used_count = out_used_r;
  assign out_heap_count = HCNT_W'(out_hcnt_r);

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(CAP))
    else $error("free stack depth beyond capacity");

  a_heaps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heaps_ext <= LW'(MAX_HEAPS))
    else $error("heap count beyond limit");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("stack read and write in one cycle");

  a_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_WAIT))
    else $error("read data not consumed in the wait state");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (depth_r != '0))
    else $error("pop from an empty stack");
`endif

endmodule : tile_free_list_allocator_core

`default_nettype wire

FILE: rtl/tfla_stack_mem.sv
// Free-stack storage: one write port, one read port with registered data.
`default_nettype none

module tfla_stack_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [AW-1:0]         wr_addr,
  input  tfla_pkg::entry_t     wr_data,
  input  wire                  rd_en,
  input  wire [AW-1:0]         rd_addr,
  output tfla_pkg::entry_t     rd_data
);
  import tfla_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : tfla_stack_mem

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for tile_free_list_allocator_core with a built-in free-stack predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfla_pkg::*;

  localparam int MAX_HEAPS       = 16;
  localparam int TILES_PER_BLOCK = 64;
  localparam int MAX_REQUEST     = 64;
  localparam int STACK_CAP       = MAX_HEAPS * TILES_PER_BLOCK;
  localparam int USED_MAX        = 2047;

  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;       // idle margin before a register write
  localparam int DRAIN_LIMIT   = 50000;   // cycles allowed for the final drain
  localparam int RUN_LIMIT_NS  = 3000000; // hard stop for the whole run
  localparam int PRINT_CAP     = 50;      // keep the log short

  // One input beat: allocate a run of tiles or free one tile
  typedef struct packed {
    logic              op;
    logic [COUNT_W-1:0] count;
    logic [HEAP_W-1:0]  heap;
    logic [TILE_W-1:0]  tile;
  } request_t;

  // One result beat as seen on the out_ ports
  typedef struct packed {
    status_t            status;
    logic               tile_valid;
    logic [HEAP_W-1:0]  heap;
    logic [TILE_W-1:0]  tile;
    logic               last;
    logic [USED_W-1:0]  used;
    logic [HCNT_W-1:0]  heaps;
  } result_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               in_operation  = 1'b0;
  logic [COUNT_W-1:0] in_count      = '0;
  logic [HEAP_W-1:0]  in_freed_heap = '0;
  logic [TILE_W-1:0]  in_freed_tile = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            out_status;
  logic               out_tile_valid;
  logic [HEAP_W-1:0]  out_heap_index;
  logic [TILE_W-1:0]  out_tile_index;
  logic               out_last;
  logic [USED_W-1:0]  out_used_count;
  logic [HCNT_W-1:0]  out_heap_count;

  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [MAXH_W-1:0]  cfg_max_heaps = '0;

  tile_free_list_allocator_core #(
    .MAX_HEAPS      (MAX_HEAPS),
    .TILES_PER_BLOCK(TILES_PER_BLOCK),
    .MAX_REQUEST    (MAX_REQUEST)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_count      (in_count),
    .in_freed_heap (in_freed_heap),
    .in_freed_tile (in_freed_tile),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_tile_valid(out_tile_valid),
    .out_heap_index(out_heap_index),
    .out_tile_index(out_tile_index),
    .out_last      (out_last),
    .out_used_count(out_used_count),
    .out_heap_count(out_heap_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_max_heaps (cfg_max_heaps)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the free stack, counters and register
  // ---------------------------------------------------------------------------
  entry_t            free_tiles [STACK_CAP];
  int unsigned       free_depth  = 0;
  int unsigned       heaps_built = 0;
  int unsigned       tiles_held  = 0;
  logic [MAXH_W-1:0] heap_cap    = 5'd16;

  request_t     tile_requests[$];     // beats waiting for the driver
  result_beat_t tile_results_due[$];  // predicted result beats, oldest first

  int unsigned requests_queued = 0;
  int unsigned requests_taken  = 0;
  int unsigned cfg_writes      = 0;
  int unsigned beats_seen      = 0;
  int unsigned mismatches      = 0;

  // Idle rates in percent per cycle, changed by the stimulus thread
  int unsigned send_gap_pct = 10;
  int unsigned recv_gap_pct = 71;

  // Long receiver hold-off: the stimulus thread bumps hold_reqs, the stall
  // process serves each request by counting HOLD_CYCLES on its own
  int unsigned hold_reqs   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  logic in_taken = 1'b0;  // the last rising edge accepted an input beat

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic string beat_text(result_beat_t b);
    return $sformatf("st=%0d v=%0b heap=%0d tile=%0d last=%0b used=%0d heaps=%0d",
                     b.status, b.tile_valid, b.heap, b.tile, b.last, b.used, b.heaps);
  endfunction

  // Append one predicted beat carrying the counters as they stand now
  function automatic void queue_beat(status_t st, logic v, logic [HEAP_W-1:0] h,
                                     logic [TILE_W-1:0] t, logic l);
    result_beat_t b;
    b.status     = st;
    b.tile_valid = v;
    b.heap       = h;
    b.tile       = t;
    b.last       = l;
    b.used       = USED_W'(tiles_held);
    b.heaps      = HCNT_W'(heaps_built);
    tile_results_due.insert(tile_results_due.size(), b);
  endfunction

  // Push a tile on the free stack; drop it when the stack is full
  function automatic bit push_free_tile(entry_t e);
    if (free_depth >= STACK_CAP)
      return 1'b0;
    free_tiles[free_depth] = e;
    free_depth++;
    return 1'b1;
  endfunction

  // Advance the predicted allocator by one accepted input beat
  function automatic void step_free_list(request_t r);
    int unsigned lim;
    int unsigned n;
    status_t     st;
    entry_t      e;
    if (r.op == OP_FREE) begin
      e.heap = r.heap;
      e.tile = r.tile;
      st = push_free_tile(e) ? ST_OK : ST_DROP;
      // the used count drops even when the tile was dropped
      if (tiles_held > 0)
        tiles_held--;
      queue_beat(st, 1'b0, '0, '0, 1'b1);
      return;
    end
    n = r.count;
    if (n == 0) begin
      queue_beat(ST_OK, 1'b0, '0, '0, 1'b1);
      return;
    end
    if (n > MAX_REQUEST) begin
      queue_beat(ST_FAIL, 1'b0, '0, '0, 1'b1);
      return;
    end
    lim = (heap_cap < MAX_HEAPS) ? heap_cap : MAX_HEAPS;
    // grow one heap at a time; heaps added before a failure stay
    while (free_depth < n) begin
      if (heaps_built >= lim) begin
        queue_beat(ST_FAIL, 1'b0, '0, '0, 1'b1);
        return;
      end
      for (int t = TILES_PER_BLOCK - 1; t >= 0; t--) begin
        e.heap = HEAP_W'(heaps_built);
        e.tile = TILE_W'(t);
        void'(push_free_tile(e));
      end
      heaps_built++;
    end
    tiles_held = (tiles_held + n > USED_MAX) ? USED_MAX : tiles_held + n;
    for (int k = 0; k < n; k++) begin
      free_depth--;
      e = free_tiles[free_depth];
      queue_beat(ST_OK, 1'b1, e.heap, e.tile, (k == n - 1));
    end
  endfunction

  // Compare one accepted result beat with the oldest prediction
  task automatic check_result_beat();
    result_beat_t got;
    result_beat_t want;
    string        wrong;
    got = '{out_status, out_tile_valid, out_heap_index, out_tile_index,
            out_last, out_used_count, out_heap_count};
    if (tile_results_due.size() == 0) begin
      report_mismatch({"result beat with nothing expected: ", beat_text(got)});
      return;
    end
    want  = tile_results_due.pop_front();
    wrong = "";
    if (got.status     !== want.status)     wrong = {wrong, " status"};
    if (got.tile_valid !== want.tile_valid) wrong = {wrong, " tile_valid"};
    if (got.heap       !== want.heap)       wrong = {wrong, " heap_index"};
    if (got.tile       !== want.tile)       wrong = {wrong, " tile_index"};
    if (got.last       !== want.last)       wrong = {wrong, " last"};
    if (got.used       !== want.used)       wrong = {wrong, " used_count"};
    if (got.heaps      !== want.heaps)      wrong = {wrong, " heap_count"};
    if (wrong != "")
      report_mismatch($sformatf("beat %0d wrong%s | got %s | want %s",
                                beats_seen, wrong, beat_text(got), beat_text(want)));
    beats_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample every channel at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    request_t r;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      // the register takes effect for every beat accepted from this edge on
      if (cfg_valid && cfg_ready) begin
        heap_cap = cfg_max_heaps;
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        r = '{in_operation, in_count, in_freed_heap, in_freed_tile};
        step_free_list(r);
        requests_taken++;
      end
      if (out_valid && !out_stall)
        check_result_beat();
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer beats from tile_requests at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      // previous beat gone (or none offered): load the next one or idle
      if (tile_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        r = tile_requests.pop_front();
        in_valid      <= 1'b1;
        in_operation  <= r.op;
        in_count      <= r.count;
        in_freed_heap <= r.heap;
        in_freed_tile <= r.tile;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // else hold the stalled beat as it is
  end

  // Receiver: random stalls, plus the long hold-off when one is requested
  always @(negedge clk) begin : drive_out_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_alloc(int unsigned n);
    request_t r;
    r.op    = OP_ALLOC;
    r.count = COUNT_W'(n);
    // free fields are don't-care here; toggle them anyway
    r.heap  = HEAP_W'($urandom);
    r.tile  = TILE_W'($urandom);
    tile_requests.insert(tile_requests.size(), r);
    requests_queued++;
  endfunction

  function automatic void queue_free(int unsigned h, int unsigned t);
    request_t r;
    r.op    = OP_FREE;
    r.count = COUNT_W'($urandom);
    r.heap  = HEAP_W'(h);
    r.tile  = TILE_W'(t);
    tile_requests.insert(tile_requests.size(), r);
    requests_queued++;
  endfunction

  function automatic void queue_random_mix(int unsigned n);
    int unsigned roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50)      queue_free($urandom_range(0, 15), $urandom_range(0, 63));
      else if (roll < 82) queue_alloc($urandom_range(1, 4));
      else if (roll < 88) queue_alloc(0);
      else if (roll < 96) queue_alloc($urandom_range(5, MAX_REQUEST));
      else                queue_alloc($urandom_range(MAX_REQUEST + 1, 127));
    end
  endfunction

  // Hold the sender until every queued beat is taken and every result is back
  task automatic wait_drained();
    while (requests_taken != requests_queued || tile_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write max_heaps while the block idles
  task automatic write_max_heaps(input logic [MAXH_W-1:0] v);
    int unsigned seen;
    wait_drained();
    seen = cfg_writes;
    cfg_max_heaps <= v;
    cfg_valid     <= 1'b1;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned waited;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: no growth allowed, so every tile comes from frees
    write_max_heaps(5'd0);
    queue_alloc(0);                      // zero count: ok, no tile
    queue_alloc(1);                      // empty stack, limit zero: fail
    queue_alloc(MAX_REQUEST);            // largest legal count still fails
    queue_alloc(MAX_REQUEST + 1);        // over the request limit
    queue_alloc(127);                    // all count bits set
    queue_free(15, 63);                  // free with used count at zero
    queue_free(0, 0);
    queue_free(9, 42);
    queue_alloc(2);                      // pops (9,42) then (0,0)
    queue_alloc(2);                      // only one tile left: fail
    queue_alloc(1);                      // pops (15,63)
    queue_free(6, 21);
    queue_free(3, 12);
    queue_free(12, 55);                  // used count back to zero

    // Free a batch of tiles at zero used count while the receiver holds off
    // for a long stretch, so the block backs up into its input.
    repeat (24) queue_free($urandom_range(0, 15), $urandom_range(0, 63));
    hold_reqs++;

    // Grow up to a mid heap limit and fail there
    send_gap_pct = 71;
    recv_gap_pct = 10;
    write_max_heaps(5'd5);
    repeat (5) queue_alloc(MAX_REQUEST);
    queue_alloc(MAX_REQUEST);            // heap limit reached
    queue_alloc(1);

    // Grow to the last heap
    write_max_heaps(5'd16);
    repeat (MAX_HEAPS - 5) queue_alloc(MAX_REQUEST);
    queue_alloc(MAX_REQUEST);            // no heap left
    queue_free(7, 33);
    queue_alloc(1);

    // Random mix under each idling pattern and several register settings
    send_gap_pct = 10;
    recv_gap_pct = 71;
    write_max_heaps(5'd31);
    queue_random_mix(35);
    wait_drained();
    queue_random_mix(25);

    send_gap_pct = 71;
    recv_gap_pct = 10;
    write_max_heaps(5'd0);
    queue_random_mix(55);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_max_heaps(MAXH_W'($urandom_range(1, 15)));
    queue_random_mix(55);

    // Let everything drain, then allow for any late beat
    waited = 0;
    while ((requests_taken != requests_queued || tile_results_due.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (requests_taken != requests_queued || tile_results_due.size() != 0)
      report_mismatch($sformatf("%0d beats never taken, %0d result beats never came",
                                requests_queued - requests_taken,
                                tile_results_due.size()));

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
